// ===== rtl/btrq_pkg.sv =====
// Package with the shared widths, status codes and state type of the batching task ring queue.
`default_nettype none
package btrq_pkg;

  localparam int HANDLE_W = 16;
  localparam int IMAGES_W = 10;
  localparam int STATUS_W = 3;
  localparam int USED_W   = 10;
  localparam int BATCH_W  = 9;
  localparam int SLOT_W   = HANDLE_W + IMAGES_W;
  localparam int GATH_W   = 12;

  localparam logic [BATCH_W-1:0] BATCH_RESET = 9'd16;

  localparam logic KIND_ENQUEUE = 1'b0;
  localparam logic KIND_DEQUEUE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_ACCEPTED = 3'd0,
    ST_FULL     = 3'd1,
    ST_ZERO     = 3'd2,
    ST_TAKEN    = 3'd3,
    ST_EMPTY    = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_DATA = 2'b10
  } state_t;

endpackage
`default_nettype wire

// ===== rtl/btrq_if.sv =====
// Channel interfaces of the batching task ring queue: request, result and configuration.
`default_nettype none
interface btrq_in_if import btrq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                kind;
  logic [HANDLE_W-1:0] task_handle;
  logic [IMAGES_W-1:0] image_count;
  modport source (output valid, kind, task_handle, image_count, input ready);
  modport sink (input valid, kind, task_handle, image_count, output ready);
endinterface

interface btrq_out_if import btrq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [HANDLE_W-1:0] out_handle;
  logic [IMAGES_W-1:0] out_images;
  logic                last_of_run;
  logic [USED_W-1:0]   entries_used;
  modport source (output valid, status, out_handle, out_images, last_of_run, entries_used,
                  input ready);
  modport sink (input valid, status, out_handle, out_images, last_of_run, entries_used,
                output ready);
endinterface

interface btrq_cfg_if import btrq_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [BATCH_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/batching_task_ring_queue_unit.sv =====
// Top level of the batching task ring queue: slot memory, head and count, dequeue sequencer.
`default_nettype none
// The queue keeps its tasks in one slot memory with a single write port and a registered read
// port. An enqueue beat or an empty dequeue beat gives one result beat. A dequeue that takes
// k tasks first reads the first slot, then gives one result beat per cycle while the result
// channel is free, because each task is read from the slot memory in turn through its one read
// port. A stalled result channel holds the sequencer. The slot memory needs no clearing after
// reset, since a slot is read only after it was written.
module batching_task_ring_queue_unit import btrq_pkg::*; #(
  parameter int QUEUE_DEPTH = 512,
  parameter int MAX_TAKE    = 16
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  btrq_in_if.sink     in_ch,
  btrq_out_if.source  out_ch,
  btrq_cfg_if.sink    cfg_ch
);

  localparam int HW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int SW = CW + 1;
  localparam int TW = $clog2(MAX_TAKE + 1);

  logic [SLOT_W-1:0] mem [QUEUE_DEPTH];
  logic [SLOT_W-1:0] rd_data_r;
  logic              mem_we;
  logic [HW-1:0]     wr_addr;
  logic [SLOT_W-1:0] wr_data;
  logic              rd_en;
  logic [HW-1:0]     rd_addr;

  state_t              state_r, state_nxt;
  logic [HW-1:0]       head_r, head_nxt;
  logic [CW-1:0]       used_r, used_nxt;
  logic [GATH_W-1:0]   gath_r, gath_nxt;
  logic [TW-1:0]       taken_r, taken_nxt;
  logic [BATCH_W-1:0]  batch_r;

  logic                out_vld_r, out_vld_nxt;
  logic [STATUS_W-1:0] st_r, st_nxt;
  logic [HANDLE_W-1:0] hnd_r, hnd_nxt;
  logic [IMAGES_W-1:0] img_r, img_nxt;
  logic                last_r, last_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [CW+USED_W-1:0] cnt_ext;

  logic              out_free;
  logic              in_acc;
  logic [SW-1:0]     tail_sum;
  logic [HW:0]       head_inc;
  logic [HW-1:0]     head_adv;
  logic [GATH_W-1:0] limit;
  logic [GATH_W-1:0] gath_add;
  logic [CW-1:0]     used_dec;
  logic [TW-1:0]     taken_inc;
  logic              run_last;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign out_free = !out_vld_r || out_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE) && out_free;
  assign in_acc = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign tail_sum = SW'(head_r) + SW'(used_r);
  assign wr_addr = (tail_sum >= SW'(QUEUE_DEPTH)) ? HW'(tail_sum - SW'(QUEUE_DEPTH))
                                                  : HW'(tail_sum);
  assign wr_data = {in_ch.image_count, in_ch.task_handle};

  assign head_inc = {1'b0, head_r} + (HW+1)'(1);
  assign head_adv = (head_inc == (HW+1)'(QUEUE_DEPTH)) ? '0 : head_inc[HW-1:0];
  assign limit = (batch_r == '0) ? GATH_W'(2) : GATH_W'({batch_r, 1'b0});
  assign gath_add = gath_r + GATH_W'(rd_data_r[SLOT_W-1:HANDLE_W]);
  assign used_dec = used_r - CW'(1);
  assign taken_inc = taken_r + TW'(1);
  assign run_last = !((taken_inc < TW'(MAX_TAKE)) && (used_dec != '0) && (gath_add < limit));

  always_comb begin
    state_nxt   = state_r;
    head_nxt    = head_r;
    used_nxt    = used_r;
    gath_nxt    = gath_r;
    taken_nxt   = taken_r;
    out_vld_nxt = out_vld_r;
    st_nxt      = st_r;
    hnd_nxt     = hnd_r;
    img_nxt     = img_r;
    last_nxt    = last_r;
    cnt_nxt     = cnt_r;
    mem_we      = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = head_r;
    if (out_vld_r && out_ch.ready) begin
      out_vld_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          hnd_nxt  = '0;
          img_nxt  = '0;
          last_nxt = 1'b1;
          cnt_nxt  = used_r;
          if (in_ch.kind == KIND_ENQUEUE) begin
            out_vld_nxt = 1'b1;
            if (in_ch.image_count == '0) begin
              st_nxt = ST_ZERO;
            end else if (used_r == CW'(QUEUE_DEPTH)) begin
              st_nxt = ST_FULL;
            end else begin
              mem_we   = 1'b1;
              used_nxt = used_r + CW'(1);
              cnt_nxt  = used_r + CW'(1);
              st_nxt   = ST_ACCEPTED;
            end
          end else if (used_r == '0) begin
            out_vld_nxt = 1'b1;
            st_nxt      = ST_EMPTY;
          end else begin
            rd_en     = 1'b1;
            gath_nxt  = '0;
            taken_nxt = '0;
            state_nxt = S_DATA;
          end
        end
      end
      S_DATA: begin
        if (out_free) begin
          out_vld_nxt = 1'b1;
          st_nxt      = ST_TAKEN;
          hnd_nxt     = rd_data_r[HANDLE_W-1:0];
          img_nxt     = rd_data_r[SLOT_W-1:HANDLE_W];
          last_nxt    = run_last;
          cnt_nxt     = used_dec;
          head_nxt    = head_adv;
          used_nxt    = used_dec;
          gath_nxt    = gath_add;
          taken_nxt   = taken_inc;
          if (run_last) begin
            state_nxt = S_IDLE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = head_adv;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      head_r    <= '0;
      used_r    <= '0;
      out_vld_r <= 1'b0;
      batch_r   <= BATCH_RESET;
    end else begin
      state_r   <= state_nxt;
      head_r    <= head_nxt;
      used_r    <= used_nxt;
      out_vld_r <= out_vld_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        batch_r <= cfg_ch.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    gath_r  <= gath_nxt;
    taken_r <= taken_nxt;
    st_r    <= st_nxt;
    hnd_r   <= hnd_nxt;
    img_r   <= img_nxt;
    last_r  <= last_nxt;
    cnt_r   <= cnt_nxt;
  end

  assign cnt_ext = {{USED_W{1'b0}}, cnt_r};

  assign out_ch.valid        = out_vld_r;
  assign out_ch.status       = st_r;
  assign out_ch.out_handle   = hnd_r;
  assign out_ch.out_images   = img_r;
  assign out_ch.last_of_run  = last_r;
  assign out_ch.entries_used = cnt_ext[USED_W-1:0];

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CW'(QUEUE_DEPTH))
    else $error("queue count exceeds the depth");

  a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
    head_r < HW'(QUEUE_DEPTH) || QUEUE_DEPTH == (1 << HW))
    else $error("head index outside the slot memory");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DATA) |-> !in_ch.ready)
    else $error("request accepted during a dequeue run");

  a_run_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.kind == KIND_DEQUEUE && used_r != '0) |=> (state_r == S_DATA))
    else $error("dequeue of a non-empty queue did not start a run");

endmodule
`default_nettype wire

// ===== tb/btrq_checker.sv =====
// Checker of the batching task ring queue: watches the channels, predicts every result beat and compares.
`timescale 1ns / 100ps
module btrq_checker import btrq_pkg::*; #(
  parameter int QUEUE_DEPTH = 512,
  parameter int MAX_TAKE    = 16
) (
  input  logic clk,
  input  logic rst_n,
  btrq_in_if   in_ch,
  btrq_out_if  out_ch,
  btrq_cfg_if  cfg_ch,
  output int   mismatches,
  output int   awaited,
  output int   queued,
  output int   beats_checked
);

  typedef struct packed {
    status_t             status;
    logic [HANDLE_W-1:0] handle;
    logic [IMAGES_W-1:0] images;
    logic                last;
    logic [USED_W-1:0]   used;
  } result_beat_t;

  logic [SLOT_W-1:0]  task_ring [QUEUE_DEPTH];
  int unsigned        ring_head;
  int unsigned        ring_used;
  logic [BATCH_W-1:0] batch_reg;
  result_beat_t       pending_beats [$];
  int                 fail_total = 0;
  int                 pending_count = 0;
  int                 checked_total = 0;

  assign mismatches    = fail_total;
  assign awaited       = pending_count;
  assign queued        = ring_used;
  assign beats_checked = checked_total;

  function automatic void note_result(status_t status, logic [HANDLE_W-1:0] handle,
                                      logic [IMAGES_W-1:0] images, logic last);
    result_beat_t beat;
    beat.status = status;
    beat.handle = handle;
    beat.images = images;
    beat.last   = last;
    beat.used   = ring_used[USED_W-1:0];
    pending_beats.push_back(beat);
  endfunction

  task automatic predict_request(input logic kind, input logic [HANDLE_W-1:0] handle,
                                 input logic [IMAGES_W-1:0] images);
    int unsigned       limit;
    int unsigned       gathered;
    int unsigned       taken;
    logic [SLOT_W-1:0] slot;
    logic              done;
    if (kind == KIND_ENQUEUE) begin
      if (images == '0) begin
        note_result(ST_ZERO, '0, '0, 1'b1);
      end else if (ring_used >= QUEUE_DEPTH) begin
        note_result(ST_FULL, '0, '0, 1'b1);
      end else begin
        task_ring[(ring_head + ring_used) % QUEUE_DEPTH] = {images, handle};
        ring_used++;
        note_result(ST_ACCEPTED, '0, '0, 1'b1);
      end
    end else if (ring_used == 0) begin
      note_result(ST_EMPTY, '0, '0, 1'b1);
    end else begin
      // A zero batch register counts as one batch image.
      limit    = 2 * ((batch_reg == '0) ? 1 : int'(batch_reg));
      gathered = 0;
      taken    = 0;
      done     = 1'b0;
      while (!done) begin
        slot      = task_ring[ring_head];
        gathered += slot[SLOT_W-1:HANDLE_W];
        ring_head = (ring_head + 1) % QUEUE_DEPTH;
        ring_used--;
        taken++;
        done = (taken >= MAX_TAKE) || (ring_used == 0) || (gathered >= limit);
        note_result(ST_TAKEN, slot[HANDLE_W-1:0], slot[SLOT_W-1:HANDLE_W], done);
      end
    end
  endtask

  function automatic void compare_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", field, want, got);
      fail_total++;
    end
  endfunction

  task automatic check_beat();
    result_beat_t want;
    if (pending_beats.size() == 0) begin
      $error("result beat with no request waiting: status %0d, handle %0d",
             out_ch.status, out_ch.out_handle);
      fail_total++;
    end else begin
      want = pending_beats.pop_front();
      compare_field("status", want.status, out_ch.status);
      compare_field("out_handle", want.handle, out_ch.out_handle);
      compare_field("out_images", want.images, out_ch.out_images);
      compare_field("last_of_run", want.last, out_ch.last_of_run);
      compare_field("entries_used", want.used, out_ch.entries_used);
    end
    checked_total++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      ring_head = 0;
      ring_used = 0;
      batch_reg = BATCH_RESET;
      pending_beats.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        batch_reg = cfg_ch.data;
      end
      if (in_ch.valid && in_ch.ready) begin
        predict_request(in_ch.kind, in_ch.task_handle, in_ch.image_count);
      end
      if (out_ch.valid && out_ch.ready) begin
        check_beat();
      end
    end
    pending_count = pending_beats.size();
  end

endmodule

// ===== tb/tb_batching_task_ring_queue_unit.sv =====
// Testbench top of the batching task ring queue: clock, reset, stimulus, idling and verdict.
`timescale 1ns / 100ps
module tb_batching_task_ring_queue_unit;
  import btrq_pkg::*;

  localparam int QUEUE_DEPTH  = 512;
  localparam int MAX_TAKE     = 16;
  localparam int IDLE_LIMIT   = 4000;
  localparam int DRAIN_CYCLES = 24;

  logic                clk         = 1'b0;
  logic                rst_n       = 1'b0;
  logic                in_valid    = 1'b0;
  logic                in_kind     = KIND_ENQUEUE;
  logic [HANDLE_W-1:0] in_handle   = '0;
  logic [IMAGES_W-1:0] in_images   = '0;
  logic                out_ready   = 1'b0;
  logic                cfg_valid   = 1'b0;
  logic [BATCH_W-1:0]  cfg_data    = '0;
  int                  send_idle_pct = 27;
  int                  recv_idle_pct = 70;
  int                  idle_cycles   = 0;
  int                  enq_sent      = 0;
  int                  deq_sent      = 0;
  int                  mismatches;
  int                  awaited;
  int                  queued;
  int                  beats_checked;

  btrq_in_if  in_bus ();
  btrq_out_if out_bus ();
  btrq_cfg_if cfg_bus ();

  assign in_bus.valid       = in_valid;
  assign in_bus.kind        = in_kind;
  assign in_bus.task_handle = in_handle;
  assign in_bus.image_count = in_images;
  assign out_bus.ready      = out_ready;
  assign cfg_bus.valid      = cfg_valid;
  assign cfg_bus.data       = cfg_data;

  batching_task_ring_queue_unit #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .MAX_TAKE    (MAX_TAKE)
  ) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  btrq_checker #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .MAX_TAKE    (MAX_TAKE)
  ) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_bus),
    .out_ch        (out_bus),
    .cfg_ch        (cfg_bus),
    .mismatches    (mismatches),
    .awaited       (awaited),
    .queued        (queued),
    .beats_checked (beats_checked)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_bus.ready) || (out_bus.valid && out_ready) ||
        (cfg_valid && cfg_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_request(input logic kind, input logic [HANDLE_W-1:0] handle,
                              input logic [IMAGES_W-1:0] images);
    int gap;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      gap      = $urandom_range(3, 1);
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  = 1'b1;
    in_kind   = kind;
    in_handle = handle;
    in_images = images;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    @(negedge clk);
    if (kind == KIND_ENQUEUE) begin
      enq_sent++;
    end else begin
      deq_sent++;
    end
  endtask

  task automatic hold_until_drained();
    in_valid = 1'b0;
    while (awaited != 0) @(negedge clk);
  endtask

  task automatic write_batch(input logic [BATCH_W-1:0] value);
    hold_until_drained();
    cfg_valid = 1'b1;
    cfg_data  = value;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic send_random(input int enq_pct);
    logic                kind;
    logic [IMAGES_W-1:0] images;
    int                  pick;
    kind = ($urandom_range(99) < enq_pct) ? KIND_ENQUEUE : KIND_DEQUEUE;
    pick = $urandom_range(99);
    if (pick < 5) begin
      images = '0;
    end else if (pick < 12) begin
      images = 10'd1023;
    end else if (pick < 45) begin
      images = IMAGES_W'($urandom_range(8, 1));
    end else begin
      images = IMAGES_W'($urandom_range(1023, 1));
    end
    if ($urandom_range(99) < 2) begin
      hold_until_drained();
    end
    send_request(kind, HANDLE_W'($urandom_range(16'hFFFF, 0)), images);
  endtask

  task automatic run_random(input int count, input int enq_pct);
    repeat (count) send_random(enq_pct);
  endtask

  task automatic drain_queue();
    while (queued != 0) begin
      send_request(KIND_DEQUEUE, HANDLE_W'($urandom_range(16'hFFFF, 0)), '0);
    end
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    send_request(KIND_DEQUEUE, 16'hFFFF, 10'd1023);
    send_request(KIND_ENQUEUE, 16'hFFFF, '0);
    send_request(KIND_ENQUEUE, 16'h0000, 10'd1023);
    send_request(KIND_ENQUEUE, 16'hFFFF, 10'd1);
    send_request(KIND_DEQUEUE, 16'h0000, '0);
    send_request(KIND_DEQUEUE, 16'h5A5A, 10'd512);
    for (int i = 0; i < MAX_TAKE + 1; i++) begin
      send_request(KIND_ENQUEUE, HANDLE_W'(16'hA500 + i), 10'd1);
    end
    send_request(KIND_DEQUEUE, 16'h0000, '0);
    send_request(KIND_DEQUEUE, 16'h0000, '0);

    write_batch(9'd1);
    run_random(30, 60);

    send_idle_pct = 70;
    recv_idle_pct = 27;
    write_batch(9'd256);
    run_random(30, 60);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_batch(9'd511);
    drain_queue();
    repeat (QUEUE_DEPTH + 1) begin
      send_request(KIND_ENQUEUE, HANDLE_W'($urandom_range(16'hFFFF, 0)),
                   IMAGES_W'($urandom_range(8, 1)));
    end
    send_request(KIND_ENQUEUE, 16'hFFFF, '0);
    drain_queue();
    send_request(KIND_DEQUEUE, 16'h0000, '0);

    write_batch(9'd0);
    run_random(40, 55);

    hold_until_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("Run covered %0d enqueue and %0d dequeue requests at batch sizes 16, 1, 256, 511 and 0.",
             enq_sent, deq_sent);
    $display("%0d result beats checked, with a full ring, wrap-around and empty dequeues.",
             beats_checked);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/btrq_pkg.sv
rtl/btrq_if.sv
rtl/batching_task_ring_queue_unit.sv
tb/btrq_checker.sv
tb/tb_batching_task_ring_queue_unit.sv
